[src/tlf_pkg.sv]
// shared types, codes and constants of the line-follower controller
`timescale 1ns / 1ps

package tlf_pkg;

  typedef enum logic [3:0] {
    ST_INIT    = 4'd0,
    ST_LINE    = 4'd1,
    ST_LEFT    = 4'd2,
    ST_RIGHT   = 4'd3,
    ST_CORNER  = 4'd4,
    ST_TURN    = 4'd5,
    ST_WIGGLE  = 4'd6,
    ST_REVERSE = 4'd7,
    ST_INCHR   = 4'd8,
    ST_INCHL   = 4'd9
  } state_e;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_FOUND = 2'd1,
    REQ_LOST  = 2'd2,
    REQ_START = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    SEN_FRONT  = 2'd0,
    SEN_LEFT   = 2'd1,
    SEN_RIGHT  = 2'd2,
    SEN_CENTER = 2'd3
  } sensor_e;

  typedef enum logic [2:0] {
    DRV_NONE       = 3'd0,
    DRV_FORWARD    = 3'd1,
    DRV_TURN_RIGHT = 3'd2,
    DRV_TURN_LEFT  = 3'd3,
    DRV_TANK_RIGHT = 3'd4,
    DRV_TANK_LEFT  = 3'd5,
    DRV_REVERSE    = 3'd6
  } drive_e;

  typedef enum logic [2:0] {
    REG_REVERSE    = 3'd0,
    REG_WIGGLE     = 3'd1,
    REG_TURN       = 3'd2,
    REG_INCH_RIGHT = 3'd3,
    REG_INCH_LEFT  = 3'd4
  } reg_e;

  localparam int unsigned TickW = 16;
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  localparam logic [TickW-1:0] ReverseReset   = 16'd600;
  localparam logic [TickW-1:0] WiggleReset    = 16'd400;
  localparam logic [TickW-1:0] TurnReset      = 16'd4000;
  localparam logic [TickW-1:0] InchRightReset = 16'd3;
  localparam logic [TickW-1:0] InchLeftReset  = 16'd3;

  typedef struct packed {
    logic [TickW-1:0] reverse_ticks;
    logic [TickW-1:0] wiggle_ticks;
    logic [TickW-1:0] turn_ticks;
    logic [TickW-1:0] inch_right_ticks;
    logic [TickW-1:0] inch_left_ticks;
  } cfg_t;

  typedef struct packed {
    state_e state;
    drive_e drive;
    logic   changed;
  } result_t;

  function automatic drive_e drive_of(state_e s);
    drive_e d;
    case (s)
      ST_INIT:    d = DRV_NONE;
      ST_LINE:    d = DRV_FORWARD;
      ST_LEFT:    d = DRV_TURN_RIGHT;
      ST_RIGHT:   d = DRV_TURN_LEFT;
      ST_CORNER:  d = DRV_FORWARD;
      ST_TURN:    d = DRV_TANK_RIGHT;
      ST_WIGGLE:  d = DRV_TANK_LEFT;
      ST_REVERSE: d = DRV_REVERSE;
      ST_INCHR:   d = DRV_TURN_RIGHT;
      ST_INCHL:   d = DRV_TURN_LEFT;
      default:    d = DRV_NONE;
    endcase
    return d;
  endfunction

endpackage

[src/tlf_if.sv]
// request and result channel interfaces of the line-follower controller
`timescale 1ns / 1ps

interface tlf_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [1:0] sensor_id;
  logic       front_on;
  logic       left_on;
  logic       right_on;

  modport source (output valid, req_type, sensor_id, front_on, left_on, right_on,
                  input ready);
  modport sink (input valid, req_type, sensor_id, front_on, left_on, right_on,
                output ready);
endinterface

interface tlf_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] state_code;
  logic [2:0] drive_cmd;
  logic       changed;

  modport source (output valid, state_code, drive_cmd, changed, input ready);
  modport sink (input valid, state_code, drive_cmd, changed, output ready);
endinterface

[src/tape_line_follower_fsm.sv]
// top level of the line-follower controller: register port, state machine, result register
`timescale 1ns / 1ps

// Line-follower controller. Each request (start, one-millisecond tick, tape detected,
// tape lost) yields exactly one result: the state after the request, its motor drive
// command and a flag that tells whether a transition happened. A request is taken
// whenever the output register is empty or the downstream side takes the waiting
// result in the same cycle: the state machine and countdown update on acceptance and
// the result appears in the output register in the cycle after acceptance, so the
// sustained rate is one request per clock while the downstream side takes every
// result. The five tick registers sit on the APB port at byte addresses 0, 4, 8, 12
// and 16; write them only while no request is in flight.
module tape_line_follower_fsm (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  tlf_req_if.sink                     req,
  tlf_rsp_if.source                   rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tlf_pkg::AddrW-1:0]   paddr,
  input  logic [tlf_pkg::DataW-1:0]   pwdata,
  output logic [tlf_pkg::DataW-1:0]   prdata,
  output logic                        pready
);

  tlf_pkg::cfg_t     cfg_q;
  tlf_pkg::result_t  result;
  tlf_pkg::result_t  out_q;
  logic              out_valid_q;
  logic              req_fire;
  logic              cfg_write;
  tlf_pkg::reg_e     reg_sel;

  assign pready    = 1'b1;
  assign reg_sel   = tlf_pkg::reg_e'(paddr[tlf_pkg::AddrW-1:2]);
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    case (reg_sel)
      tlf_pkg::REG_REVERSE:    prdata = {16'd0, cfg_q.reverse_ticks};
      tlf_pkg::REG_WIGGLE:     prdata = {16'd0, cfg_q.wiggle_ticks};
      tlf_pkg::REG_TURN:       prdata = {16'd0, cfg_q.turn_ticks};
      tlf_pkg::REG_INCH_RIGHT: prdata = {16'd0, cfg_q.inch_right_ticks};
      tlf_pkg::REG_INCH_LEFT:  prdata = {16'd0, cfg_q.inch_left_ticks};
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reverse_ticks    <= tlf_pkg::ReverseReset;
      cfg_q.wiggle_ticks     <= tlf_pkg::WiggleReset;
      cfg_q.turn_ticks       <= tlf_pkg::TurnReset;
      cfg_q.inch_right_ticks <= tlf_pkg::InchRightReset;
      cfg_q.inch_left_ticks  <= tlf_pkg::InchLeftReset;
    end else if (cfg_write) begin
      case (reg_sel)
        tlf_pkg::REG_REVERSE:    cfg_q.reverse_ticks    <= pwdata[15:0];
        tlf_pkg::REG_WIGGLE:     cfg_q.wiggle_ticks     <= pwdata[15:0];
        tlf_pkg::REG_TURN:       cfg_q.turn_ticks       <= pwdata[15:0];
        tlf_pkg::REG_INCH_RIGHT: cfg_q.inch_right_ticks <= pwdata[15:0];
        tlf_pkg::REG_INCH_LEFT:  cfg_q.inch_left_ticks  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // the output register frees up in the same cycle it is taken
  assign req.ready = !out_valid_q || rsp.ready;
  assign req_fire  = req.valid && req.ready;

  tlf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (req_fire),
    .req_type_i  (req.req_type),
    .sensor_id_i (req.sensor_id),
    .front_on_i  (req.front_on),
    .left_on_i   (req.left_on),
    .right_on_i  (req.right_on),
    .cfg_i       (cfg_q),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (req.ready) begin
      out_valid_q <= req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      out_q <= result;
    end
  end

  assign rsp.valid      = out_valid_q;
  assign rsp.state_code = out_q.state;
  assign rsp.drive_cmd  = out_q.drive;
  assign rsp.changed    = out_q.changed;

endmodule

[src/tlf_ctrl.sv]
// state machine and countdown of the line-follower controller
`timescale 1ns / 1ps

module tlf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [1:0]        req_type_i,
  input  logic [1:0]        sensor_id_i,
  input  logic              front_on_i,
  input  logic              left_on_i,
  input  logic              right_on_i,
  input  tlf_pkg::cfg_t     cfg_i,
  output tlf_pkg::result_t  result_o
);

  tlf_pkg::state_e              state_q, state_d;
  logic [tlf_pkg::TickW-1:0]    cnt_q, cnt_d;
  logic                         run_q, run_d;

  tlf_pkg::req_e                req;
  tlf_pkg::sensor_e             sen;
  logic                         tick_run;
  logic                         timeout;
  logic                         changed;
  logic                         found_front;

  assign req         = tlf_pkg::req_e'(req_type_i);
  assign sen         = tlf_pkg::sensor_e'(sensor_id_i);
  assign tick_run    = (req == tlf_pkg::REQ_TICK) && run_q;
  assign timeout     = tick_run && (cnt_q <= 16'd1);
  assign found_front = (req == tlf_pkg::REQ_FOUND) && (sen == tlf_pkg::SEN_FRONT);

  // next state
  always_comb begin
    state_d = state_q;
    changed = 1'b0;
    case (state_q)
      tlf_pkg::ST_INIT: begin
        if (req == tlf_pkg::REQ_START) begin
          state_d = tlf_pkg::ST_LINE;
          changed = 1'b1;
        end
      end
      tlf_pkg::ST_LINE: begin
        if (req == tlf_pkg::REQ_FOUND && sen == tlf_pkg::SEN_RIGHT) begin
          state_d = front_on_i ? tlf_pkg::ST_CORNER : tlf_pkg::ST_LEFT;
          changed = 1'b1;
        end else if (req == tlf_pkg::REQ_FOUND && sen == tlf_pkg::SEN_LEFT
                     && !front_on_i) begin
          state_d = tlf_pkg::ST_RIGHT;
          changed = 1'b1;
        end else if (req == tlf_pkg::REQ_LOST && sen == tlf_pkg::SEN_CENTER
                     && !front_on_i && !left_on_i && !right_on_i) begin
          state_d = tlf_pkg::ST_REVERSE;
          changed = 1'b1;
        end
      end
      tlf_pkg::ST_LEFT: begin
        if (found_front) begin
          state_d = tlf_pkg::ST_INCHR;
          changed = 1'b1;
        end
      end
      tlf_pkg::ST_RIGHT: begin
        if (found_front) begin
          state_d = tlf_pkg::ST_INCHL;
          changed = 1'b1;
        end
      end
      tlf_pkg::ST_CORNER: begin
        if (req == tlf_pkg::REQ_LOST && sen == tlf_pkg::SEN_RIGHT) begin
          state_d = tlf_pkg::ST_TURN;
          changed = 1'b1;
        end
      end
      tlf_pkg::ST_TURN: begin
        if (found_front || timeout) begin
          state_d = tlf_pkg::ST_INCHR;
          changed = 1'b1;
        end
      end
      tlf_pkg::ST_INCHR, tlf_pkg::ST_INCHL: begin
        if (timeout) begin
          state_d = tlf_pkg::ST_LINE;
          changed = 1'b1;
        end
      end
      tlf_pkg::ST_REVERSE: begin
        if (timeout) begin
          state_d = tlf_pkg::ST_WIGGLE;
          changed = 1'b1;
        end
      end
      tlf_pkg::ST_WIGGLE: begin
        if (found_front) begin
          state_d = tlf_pkg::ST_LINE;
          changed = 1'b1;
        end else if (timeout) begin
          state_d = tlf_pkg::ST_TURN;
          changed = 1'b1;
        end
      end
      default: begin
        state_d = state_q;
        changed = 1'b0;
      end
    endcase
  end

  // countdown: a tick runs it down, entering a state reloads or stops it
  always_comb begin
    cnt_d = cnt_q;
    run_d = run_q;
    if (tick_run) begin
      if (timeout) begin
        cnt_d = '0;
        run_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 16'd1;
      end
    end
    if (changed) begin
      run_d = 1'b1;
      case (state_d)
        tlf_pkg::ST_REVERSE: cnt_d = cfg_i.reverse_ticks;
        tlf_pkg::ST_WIGGLE:  cnt_d = cfg_i.wiggle_ticks;
        tlf_pkg::ST_TURN:    cnt_d = cfg_i.turn_ticks;
        tlf_pkg::ST_INCHR:   cnt_d = cfg_i.inch_right_ticks;
        tlf_pkg::ST_INCHL:   cnt_d = cfg_i.inch_left_ticks;
        default: begin
          cnt_d = '0;
          run_d = 1'b0;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    result_o.state   = state_d;
    result_o.drive   = tlf_pkg::drive_of(state_d);
    result_o.changed = changed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tlf_pkg::ST_INIT;
      cnt_q   <= '0;
      run_q   <= 1'b0;
    end else if (step_i) begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      run_q   <= run_d;
    end
  end

endmodule
